/* src/trial_division_prime_counter_top_defines.svh */
// assertion macros for the prime counter checker
`ifndef TRIAL_DIVISION_PRIME_COUNTER_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_COUNTER_TOP_DEFINES_SVH

// clocked assertion with reset disable
`define TDPC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tdpc check failed");

// clocked assertion that also holds during reset
`define TDPC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tdpc check failed");

`endif

/* src/tdpc_pkg.sv */
// shared types for the trial division prime counter
package tdpc_pkg;

   // status from the remainder unit to the sequencer
   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_stat_type;

endpackage

/* src/tdpc_div.sv */
// bit-serial restoring remainder unit, one quotient bit per cycle
module tdpc_div #(
   parameter int VALUE_BITS = 31
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [VALUE_BITS-1:0]   dividend,
   input  logic [VALUE_BITS-1:0]   divisor,
   output tdpc_pkg::div_stat_type  stat
);

   localparam int CW = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [VALUE_BITS-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;

   // one restoring step: shift in next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = CW'(VALUE_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[VALUE_BITS-1:0];
         end else begin
            rem_in = trial[VALUE_BITS-1:0];
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat.done     = done_ff;
   assign stat.rem_zero = (rem_ff == '0);

endmodule

/* src/trial_division_prime_counter_top.sv */
// each divisor tried costs a check step in the sequencer and a pass through the shared
// remainder unit; the walk stops at the first divisor found or once the divisor's square
// exceeds the number, and numbers below two are answered without a division
// throughput: one request at a time; the next request is taken while a result waits
// reset (synchronous, active high) clears the prime count and all control state
module trial_division_prime_counter_top #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_number,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_tested_value,
   output logic                  rsp_is_prime,
   output logic [VALUE_BITS-1:0] rsp_prime_count
);

   localparam int SW = VALUE_BITS + 2;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] num_ff, num_in;
   logic [VALUE_BITS-1:0] dvs_ff, dvs_in;
   logic [SW-1:0]         sq_ff, sq_in;
   logic                  prime_ff, prime_in;
   logic [VALUE_BITS-1:0] count_ff, count_in;
   logic                  out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0] out_value_ff, out_value_in;
   logic                  out_prime_ff, out_prime_in;
   logic [VALUE_BITS-1:0] out_count_ff, out_count_in;
   logic                  div_start;
   logic                  out_load;
   tdpc_pkg::div_stat_type div_stat;

   // shared remainder unit
   tdpc_div #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (dvs_ff),
      .stat     (div_stat)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign out_load  = (state_ff == ST_DONE) && (!out_valid_ff || rsp_ready);

   // sequencer: divisor walk with running square
   always_comb begin
      state_in  = state_ff;
      num_in    = num_ff;
      dvs_in    = dvs_ff;
      sq_in     = sq_ff;
      prime_in  = prime_ff;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               num_in   = req_number;
               dvs_in   = VALUE_BITS'(2);
               sq_in    = SW'(4);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (num_ff < VALUE_BITS'(2)) begin
               prime_in = 1'b0;
               state_in = ST_DONE;
            end else if (sq_ff > {2'b00, num_ff}) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (div_stat.rem_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  sq_in    = sq_ff + {1'b0, dvs_ff, 1'b1};
                  dvs_in   = dvs_ff + VALUE_BITS'(1);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // saturating prime count and output register
   always_comb begin
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_prime_in = out_prime_ff;
      out_count_in = out_count_ff;
      if (out_load) begin
         if (prime_ff && (count_ff != '1)) begin
            count_in = count_ff + VALUE_BITS'(1);
         end
         out_valid_in = 1'b1;
         out_value_in = num_ff;
         out_prime_in = prime_ff;
         out_count_in = count_in;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      dvs_ff       <= dvs_in;
      sq_ff        <= sq_in;
      prime_ff     <= prime_in;
      out_value_ff <= out_value_in;
      out_prime_ff <= out_prime_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_tested_value = out_value_ff;
   assign rsp_is_prime     = out_prime_ff;
   assign rsp_prime_count  = out_count_ff;

endmodule

/* src/tdpc_checker.sv */
// port-level checks for the prime counter, bound to the top level
`include "trial_division_prime_counter_top_defines.svh"

module tdpc_checker #(
   parameter int VALUE_BITS = 31
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [VALUE_BITS-1:0] rsp_tested_value,
   input logic                  rsp_is_prime,
   input logic [VALUE_BITS-1:0] rsp_prime_count
);

   // a stalled response holds its payload
   `TDPC_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_tested_value) && $stable(rsp_is_prime) && $stable(rsp_prime_count)))

   // the block is busy right after taking a request
   `TDPC_ASSERT(a_busy_after_req, clock, reset, (req_valid && req_ready) |=> !req_ready)

   // a prime response always carries a nonzero count
   `TDPC_ASSERT(a_prime_count, clock, reset, (rsp_valid && rsp_is_prime) |-> (rsp_prime_count != '0))

   // even numbers other than two are never prime
   `TDPC_ASSERT(a_even, clock, reset, (rsp_valid && !rsp_tested_value[0] && (rsp_tested_value != VALUE_BITS'(2))) |-> !rsp_is_prime)

   // no response leaves the block right after reset
   `TDPC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule

bind trial_division_prime_counter_top tdpc_checker #(
   .VALUE_BITS (VALUE_BITS)
) u_tdpc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_tested_value (rsp_tested_value),
   .rsp_is_prime     (rsp_is_prime),
   .rsp_prime_count  (rsp_prime_count)
);

/* bench/trial_division_prime_counter_top_test.sv */
// self-checking testbench for the trial division prime counter
module trial_division_prime_counter_top_test;

   localparam int VALUE_BITS = 31;
   // the drain after the last expected result gives time to see any stray result
   localparam int DRAIN_CYCLES = 400;
   localparam int NUM_RANDOM = 80;
   // run limit, with room to spare for the worst case stimulus below
   localparam longint CYCLE_LIMIT = 4000000;
   localparam int HOLD_OFF_AT = 30;
   localparam int HOLD_OFF_CYCLES = 5000;
   localparam int NUM_EDGE = 22;

   typedef logic [VALUE_BITS-1:0] value_t;

   typedef struct packed {
      value_t tested_value;
      logic   is_prime;
      value_t prime_count;
   } verdict_t;

   logic   clock;
   logic   reset = 1'b1;
   logic   req_valid = 1'b0;
   logic   req_ready;
   value_t req_number = '0;
   logic   rsp_valid;
   logic   rsp_ready = 1'b0;
   value_t rsp_tested_value;
   logic   rsp_is_prime;
   value_t rsp_prime_count;

   value_t   pending_numbers [$];
   verdict_t expected_verdicts [$];
   value_t   primes_seen = '0;
   int       error_count = 0;
   int       requests_accepted = 0;
   int       primes_accepted = 0;
   int       verdicts_checked = 0;
   longint   cycle_count = 0;
   bit       req_taken = 1'b0;

   // sender burst state
   int burst_left = 0;
   int gap_left = 0;

   // receiver stall state
   int stretch_left = 0;
   int stretch_mode = 0;
   int hold_off_left = 0;
   bit hold_off_done = 1'b0;

   // zero and one, two and three, perfect squares, a few primes of growing size,
   // and large values that have a small factor; the all-ones value is itself prime
   // and too slow to search, so the list does not hold it
   value_t edge_numbers [NUM_EDGE] = '{
      31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd7, 31'd9, 31'd25, 31'd49,
      31'd121, 31'd169, 31'd961, 31'd10201, 31'd65521, 31'd1018081, 31'd1000003,
      31'd2147483646, 31'd2147483645, 31'd1073741824, 31'd1431655765, 31'd715827882
   };

   int unsigned small_factors [6] = '{2, 3, 5, 7, 11, 13};

   trial_division_prime_counter_top #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_number       (req_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tested_value (rsp_tested_value),
      .rsp_is_prime     (rsp_is_prime),
      .rsp_prime_count  (rsp_prime_count)
   );

   // clock, period 12
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // reset held at the start, released on a falling edge
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // trial division with an inclusive square bound
   function automatic logic is_prime_number(value_t n);
      longint unsigned d;
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still outstanding",
                  cycle_count, expected_verdicts.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // request driver: bursts of requests with random gaps in between
   always @(negedge clock) begin : drive_requests
      logic next_valid;
      next_valid = req_valid;
      if (!reset && !(req_valid && !req_taken)) begin
         req_taken = 1'b0;
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_numbers.size() > 0) begin
            req_number <= pending_numbers.pop_front();
            next_valid = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 6);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            end
         end
      end
      req_valid <= next_valid;
   end

   // result ready: steady, choppy and stalled stretches, plus one long hold-off
   always @(negedge clock) begin : drive_ready
      logic next_ready;
      next_ready = 1'b1;
      if (!hold_off_done && verdicts_checked >= HOLD_OFF_AT) begin
         hold_off_done = 1'b1;
         hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         next_ready = 1'b0;
      end else begin
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(1, 80);
            stretch_mode = $urandom_range(0, 2);
         end
         stretch_left--;
         case (stretch_mode)
            1: begin
               next_ready = ($urandom_range(0, 2) != 0);
            end
            2: begin
               next_ready = 1'b0;
            end
            default: begin
               next_ready = 1'b1;
            end
         endcase
      end
      rsp_ready <= reset ? 1'b0 : next_ready;
   end

   // check results against the oldest expectation, predict on each accepted request
   always @(posedge clock) begin : watch_channels
      verdict_t want;
      logic     prime;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            verdicts_checked++;
            if (expected_verdicts.size() == 0) begin
               $error("result with nothing expected: tested_value %0d", rsp_tested_value);
               error_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_tested_value !== want.tested_value) begin
                  $error("tested_value: expected %0d, got %0d",
                         want.tested_value, rsp_tested_value);
                  error_count++;
               end
               if (rsp_is_prime !== want.is_prime) begin
                  $error("is_prime: expected %0d, got %0d (number %0d)",
                         want.is_prime, rsp_is_prime, want.tested_value);
                  error_count++;
               end
               if (rsp_prime_count !== want.prime_count) begin
                  $error("prime_count: expected %0d, got %0d (number %0d)",
                         want.prime_count, rsp_prime_count, want.tested_value);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            prime = is_prime_number(req_number);
            if (prime) begin
               primes_accepted++;
               // count saturates at all ones
               if (primes_seen != '1) primes_seen++;
            end
            expected_verdicts.push_back('{req_number, prime, primes_seen});
            requests_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin : run_sequence
      int          i;
      int          total_items;
      int unsigned f;
      int unsigned p;
      value_t      n;
      foreach (edge_numbers[k]) pending_numbers.push_back(edge_numbers[k]);
      for (i = 0; i < NUM_RANDOM; i++) begin
         if (i % 10 == 0) begin
            // mid range, at most about a thousand divisors
            n = value_t'($urandom_range(0, (1 << 20) - 1));
         end else if (i % 4 == 1) begin
            // full width with a small factor, so the search ends early
            f = small_factors[$urandom_range(0, 5)];
            n = value_t'(f * $urandom_range(1, 32'h7FFF_FFFF / f));
         end else if ($urandom_range(0, 3) == 0) begin
            p = $urandom_range(2, 64);
            n = value_t'(p * p);
         end else begin
            n = value_t'($urandom_range(0, 4095));
         end
         pending_numbers.push_back(n);
      end
      total_items = pending_numbers.size();

      wait (requests_accepted == total_items);
      wait (expected_verdicts.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d numbers tested, %0d primes among them, %0d results compared",
               requests_accepted, primes_accepted, verdicts_checked);
      $display("result side held off for %0d cycles once while requests kept coming",
               HOLD_OFF_CYCLES);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
